### rtl/sps_pkg.sv
package sps_pkg;

  localparam int PATTERN_MAX = 512;

  localparam int POS_W  = 31;
  localparam int LEN_W  = 10;
  localparam int SLOT_W = 9;
  localparam int BYTE_W = 8;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic              load;
    logic              start;
    logic              shift;
    logic [BYTE_W-1:0] data_byte;
    logic [SLOT_W-1:0] pattern_index;
    logic              cfg_we;
    logic [LEN_W-1:0]  cfg_len_m1;
  } sps_ctl_t;

endpackage

### rtl/sps_if.sv
interface sps_in_if;
  import sps_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [SLOT_W-1:0] pattern_index;
  logic [BYTE_W-1:0] data_byte;
  logic [POS_W-1:0]  start_position;
  logic              last_byte;

  modport source(output valid, command, pattern_index, data_byte, start_position, last_byte,
                 input ready);
  modport sink(input valid, command, pattern_index, data_byte, start_position, last_byte,
               output ready);
endinterface

interface sps_out_if;
  import sps_pkg::*;
  logic             valid;
  logic             ready;
  logic             match_found;
  logic [POS_W-1:0] match_position;

  modport source(output valid, match_found, match_position, input ready);
  modport sink(input valid, match_found, match_position, output ready);
endinterface

interface sps_cfg_if;
  import sps_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

### rtl/sps_cell.sv
module sps_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sps_pkg::sps_ctl_t ctl,
  input  logic              pm_in,
  output logic              pm_out,
  output logic              hit
);
  import sps_pkg::*;

  logic [BYTE_W-1:0] pat_r;
  logic              pm_r, pm_nxt;
  logic              tail_r, tail_nxt;
  logic              pm_new;

  assign pm_new = pm_in && (ctl.data_byte == pat_r);
  assign pm_out = pm_r;
  assign hit    = pm_new && tail_r;

  always_comb begin
    pm_nxt = pm_r;
    if (ctl.start) begin
      pm_nxt = 1'b0;
    end else if (ctl.shift) begin
      pm_nxt = pm_new;
    end
    tail_nxt = tail_r;
    if (ctl.cfg_we) begin
      tail_nxt = (int'(ctl.cfg_len_m1) == IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r   <= 1'b0;
      tail_r <= (IDX == 0);
    end else begin
      pm_r   <= pm_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && (int'(ctl.pattern_index) == IDX)) begin
      pat_r <= ctl.data_byte;
    end
  end

endmodule

### rtl/stream_pattern_search.sv
// channel | dir | payload                                              | transfer
// in_ch   | in  | command, pattern_index, data_byte, start_position,   | valid & ready
//         |     | last_byte                                            |
// out_ch  | out | match_found, match_position                          | valid & ready
// cfg_ch  | in  | data (pattern_length)                                | valid & ready
// one item per clock unless in_ch stalls: every cell compares the byte against its pattern slot in parallel
// a result is registered in the output register in the cycle after its data byte is accepted
// in_ch stalls only while a result waits in the output register and out_ch is not ready
// synchronous active-low reset clears the match chain, position, and sets the idle flag
module stream_pattern_search (
  input  logic      clk,
  input  logic      rst_n,
  sps_in_if.sink    in_ch,
  sps_out_if.source out_ch,
  sps_cfg_if.sink   cfg_ch
);
  import sps_pkg::*;

  sps_ctl_t                 ctl;
  logic [PATTERN_MAX-1:0]   pm_vec;
  logic [PATTERN_MAX-1:0]   hit_vec;
  logic                     in_acc;
  logic                     act;
  logic                     found;
  logic                     res_take;
  logic [LEN_W-1:0]         len_m1_r, len_m1_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic                     done_r, done_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_found_r, out_found_nxt;
  logic [POS_W-1:0]         out_pos_r, out_pos_nxt;
  logic [POS_W-1:0]         len_m1_ext;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign act          = in_acc && (in_ch.command == CMD_DATA) && !done_r;
  assign found        = |hit_vec;
  assign res_take     = act && (found || in_ch.last_byte);
  assign len_m1_ext   = POS_W'(len_m1_r);

  assign ctl.load          = in_acc && (in_ch.command == CMD_LOAD);
  assign ctl.start         = in_acc && (in_ch.command == CMD_START);
  assign ctl.shift         = act;
  assign ctl.data_byte     = in_ch.data_byte;
  assign ctl.pattern_index = in_ch.pattern_index;
  assign ctl.cfg_we        = cfg_ch.valid;
  assign ctl.cfg_len_m1    = len_m1_nxt;

  genvar k;
  generate
    for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
      if (k == 0) begin : g_head
        sps_cell #(.IDX(k)) u_cell (
          .clk(clk), .rst_n(rst_n), .ctl(ctl), .pm_in(1'b1),
          .pm_out(pm_vec[k]), .hit(hit_vec[k])
        );
      end else begin : g_body
        sps_cell #(.IDX(k)) u_cell (
          .clk(clk), .rst_n(rst_n), .ctl(ctl), .pm_in(pm_vec[k-1]),
          .pm_out(pm_vec[k]), .hit(hit_vec[k])
        );
      end
    end
  endgenerate

  always_comb begin
    len_m1_nxt = len_m1_r;
    if (cfg_ch.valid) begin
      len_m1_nxt = (cfg_ch.data == '0) ? '0 : cfg_ch.data - LEN_W'(1);
    end

    pos_nxt  = pos_r;
    done_nxt = done_r;
    if (ctl.start) begin
      pos_nxt  = in_ch.start_position;
      done_nxt = 1'b0;
    end else if (act) begin
      if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + POS_W'(1);
      end
      if (found || in_ch.last_byte) begin
        done_nxt = 1'b1;
      end
    end

    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = found;
      if (found && (pos_r >= len_m1_ext)) begin
        out_pos_nxt = pos_r - len_m1_ext;
      end else begin
        out_pos_nxt = '0;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_m1_r    <= '0;
      pos_r       <= '0;
      done_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      len_m1_r    <= len_m1_nxt;
      pos_r       <= pos_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.match_found    = out_found_r;
  assign out_ch.match_position = out_pos_r;

`ifndef ASSERT_OFF
  a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> done_r && out_valid_r)
    else $error("search not closed after result");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_pos_r == '0))
    else $error("not-found result carries a position");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> !done_r && ($countones(pm_vec) == 0))
    else $error("start did not clear match chain");

  a_single_tail: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one cell reports a full match");
`endif

endmodule
